// ----- design/tiex_pkg.sv -----
// ----------------------------------------------------------------------------
// tiex_pkg
// Shared types and codes for the toy ISA execute unit: opcodes, fault codes,
// compare flag bits, stream item layouts, controller/datapath interface.
// ----------------------------------------------------------------------------
package tiex_pkg;

   // opcodes
   localparam logic [7:0] OPC_ADD  = 8'd0;
   localparam logic [7:0] OPC_SUB  = 8'd1;
   localparam logic [7:0] OPC_MUL  = 8'd2;
   localparam logic [7:0] OPC_DIV  = 8'd3;
   localparam logic [7:0] OPC_IMM  = 8'd4;
   localparam logic [7:0] OPC_MOV  = 8'd5;
   localparam logic [7:0] OPC_SHOW = 8'd6;
   localparam logic [7:0] OPC_JMP  = 8'd7;
   localparam logic [7:0] OPC_CMP  = 8'd8;

   // fault codes
   localparam logic [1:0] FLT_NONE    = 2'd0;
   localparam logic [1:0] FLT_OPCODE  = 2'd1;
   localparam logic [1:0] FLT_DIVZERO = 2'd2;

   // architectural register indexes with a fixed role
   localparam logic [2:0] REG_PC    = 3'd0;
   localparam logic [2:0] REG_IMM   = 3'd1;
   localparam logic [2:0] REG_FLAGS = 3'd2;

   // compare flag bits
   localparam logic [15:0] CMP_EQL = 16'h0001;
   localparam logic [15:0] CMP_LST = 16'h0002;
   localparam logic [15:0] CMP_GRT = 16'h0004;
   localparam logic [15:0] CMP_NEQ = 16'h0008;
   localparam logic [15:0] CMP_LTE = 16'h0010;
   localparam logic [15:0] CMP_GRE = 16'h0020;
   localparam logic [15:0] CMP_AND = 16'h0040;
   localparam logic [15:0] CMP_XOR = 16'h0080;
   localparam logic [15:0] CMP_COR = 16'h0100;

   // decoded instruction, opcode in the lowest bits
   typedef struct packed {
      logic [1:0]  pad;
      logic [15:0] imm_second;
      logic [15:0] imm_first;
      logic        second_is_reg;
      logic        first_is_reg;
      logic        target_is_reg;
      logic [7:0]  jump_mask;
      logic        src_is_reg;
      logic        dest_is_reg;
      logic [2:0]  src_reg_b;
      logic [2:0]  src_reg_a;
      logic [2:0]  dest_reg;
      logic [7:0]  opcode;
   } req_item_type;

   // result, next_pc in the lowest bits
   typedef struct packed {
      logic [5:0]  pad;
      logic [15:0] flags_now;
      logic [1:0]  fault;
      logic [15:0] next_pc;
   } rsp_item_type;

   typedef enum logic [1:0] {
      RSEL_A,
      RSEL_B,
      RSEL_D
   } rf_sel_type;

   // source of a memory address to be reduced
   typedef enum logic {
      MSEL_A,
      MSEL_D
   } mod_sel_type;

   typedef struct packed {
      logic        clr;
      logic        cap_instr;
      rf_sel_type  rf_sel;
      logic        cap_a;
      logic        cap_b;
      logic        cap_d;
      logic        div_start;
      mod_sel_type mod_sel;
      logic        cap_addr;
      logic        cap_v;
      logic        mem_wr;
      logic        commit;
      logic        rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic [7:0] opcode;
      logic       src_is_reg;
      logic       dest_is_reg;
      logic       fault_any;
      logic       div_done;
      logic       clr_done;
      logic       rsp_free;
   } dp_status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_A,
      ST_RD_B,
      ST_RD_D,
      ST_EXEC,
      ST_DIV_WAIT,
      ST_MODA_WAIT,
      ST_MEM_RD,
      ST_MEM_CAP,
      ST_MODD_START,
      ST_MODD_WAIT,
      ST_MEM_WR,
      ST_MOV_WB,
      ST_DONE
   } ctrl_state_type;

endpackage

// ----- design/toy_isa_execute_unit.sv -----
// ----------------------------------------------------------------------------
// toy_isa_execute_unit
// Execute stage of a small 16-bit register machine: runs one decoded
// instruction against eight registers and a word data memory, returns the
// next program counter, a fault code and the flag register.
// ----------------------------------------------------------------------------
//
//  channel  direction  payload (lowest bits first)
//  -------  ---------  ---------------------------------------------------
//  req_     in         opcode, dest_reg, src_reg_a, src_reg_b, dest_is_reg,
//                      src_is_reg, jump_mask, target_is_reg, first_is_reg,
//                      second_is_reg, imm_first, imm_second
//  rsp_     out        next_pc, fault, flags_now
//
//  sequencing: one instruction at a time; a divide runs on a one-bit-per-cycle
//    divider; moves reduce each memory address modulo MEM_WORDS by a
//    two-stage reciprocal multiply
//  reset: register file cleared at once; data memory swept to zero before the
//    first transfer is accepted
//  stalls: a result waits in the output register while the next instruction runs
//
module toy_isa_execute_unit import tiex_pkg::*; #(
   parameter int MEM_WORDS = 64
) (
   input  logic        clock,
   input  logic        reset,
   // instruction stream
   input  logic        req_tvalid,
   output logic        req_tready,
   // opcode[7:0], dest_reg[10:8], src_reg_a[13:11], src_reg_b[16:14],
   // dest_is_reg[17], src_is_reg[18], jump_mask[26:19], target_is_reg[27],
   // first_is_reg[28], second_is_reg[29], imm_first[45:30],
   // imm_second[61:46], zero[63:62]
   input  logic [63:0] req_tdata,
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // next_pc[15:0], fault[17:16], flags_now[33:18], zero[39:34]
   output logic [39:0] rsp_tdata
);

   // sequencer commands and datapath status
   dp_cmd_type    cmd;
   dp_status_type status;

   tiex_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tiex_dpath #(
      .MEM_WORDS (MEM_WORDS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // no instruction taken while the memory sweep runs
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clr |-> !req_tready)
      else $error("instruction accepted during memory clear");

   // one instruction in flight: a transfer closes the input side
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second instruction accepted while one is in flight");

   // a result is loaded only into a free output register
   a_rsp_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_tvalid || rsp_tready))
      else $error("result overwrote a pending response");

   // commit and a divider start never coincide
   a_commit_vs_div: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !cmd.div_start)
      else $error("commit issued together with divider start");

endmodule

// ----- design/tiex_ram.sv -----
// ----------------------------------------------------------------------------
// tiex_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tiex_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AddrW-1:0] waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AddrW-1:0] raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- design/tiex_div.sv -----
// ----------------------------------------------------------------------------
// tiex_div
// Restoring divider, one quotient bit per cycle: 16-bit dividend and
// divisor, quotient held after done.
// ----------------------------------------------------------------------------
module tiex_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] dividend,
   input  logic [15:0] divisor,
   output logic [15:0] quotient,
   output logic        done
);

   logic [15:0] rem_ff, rem_in;
   logic [15:0] quo_ff, quo_in;
   logic [15:0] dvs_ff, dvs_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [16:0] trial;
   logic [16:0] diff;
   logic        fits;

   assign trial = {rem_ff, quo_ff[15]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = 5'd16;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // a partial remainder stays below the divisor, so 16 bits hold it
         rem_in = fits ? diff[15:0] : trial[15:0];
         quo_in = {quo_ff[14:0], fits};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// ----- design/tiex_dpath.sv -----
// ----------------------------------------------------------------------------
// tiex_dpath
// Execute datapath: instruction register, register file, data memory,
// operand latches, alu and compare, divider, address reduction, result register.
// ----------------------------------------------------------------------------
module tiex_dpath import tiex_pkg::*; #(
   parameter int MEM_WORDS = 64,
   localparam int AddrW = $clog2(MEM_WORDS)
) (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   input  logic [63:0]   req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [39:0]   rsp_tdata
);

   localparam logic [AddrW:0] ClrEnd  = (AddrW + 1)'(MEM_WORDS);
   // address modulo MEM_WORDS: q = (v * ModRecip) >> ModShift is exact for 16-bit v
   localparam int          ModShift = 16 + $clog2(MEM_WORDS);
   localparam logic [16:0] ModRecip =
      17'(((64'd1 << ModShift) + 64'(MEM_WORDS) - 64'd1) / 64'(MEM_WORDS));
   localparam logic [16:0] ModWords = 17'(MEM_WORDS);

   req_item_type     ins_ff, ins_in;
   logic [15:0]      pc_ff, pc_in;
   logic [15:0]      flags_ff, flags_in;
   logic [15:0]      opa_ff, opa_in;
   logic [15:0]      opb_ff, opb_in;
   logic [15:0]      opd_ff, opd_in;
   logic             bzero_ff, bzero_in;
   logic [15:0]      mv_ff, mv_in;
   logic [AddrW-1:0] addr_ff, addr_in;
   logic [AddrW:0]   clr_ff, clr_in;
   logic [7:0]       rf_valid_ff, rf_valid_in;
   logic [1:0]       fault_ff, fault_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_ff, rsp_in;
   logic [15:0]      mod_val_ff, mod_val_in;
   logic [15:0]      mod_q_ff, mod_q_in;

   logic [2:0]  ins_len;
   logic [15:0] pc_adv;
   logic [2:0]  rf_ridx;
   logic [15:0] rf_rdata;
   logic [15:0] rf_raw;
   logic [15:0] rf_eff;
   logic [1:0]  fault_now;
   logic [15:0] mul_lo;
   logic [15:0] mov_val;
   logic [15:0] cmp_val;
   logic        jmp_taken;
   logic        wr_en;
   logic [2:0]  wr_idx;
   logic [15:0] wr_val;
   logic        rf_we;
   logic [15:0] div_quo;
   logic        div_done;
   logic [15:0] mod_src;
   logic [32:0] mod_prod;
   logic [32:0] mod_back;
   logic [15:0] mod_rem;
   logic            dm_we;
   logic [AddrW-1:0] dm_waddr;
   logic [15:0]     dm_wdata;
   logic [15:0]     dm_rdata;

   function automatic logic [15:0] cmp_flags(input logic [15:0] v1, input logic [15:0] v2);
      logic [15:0] f;
      f = '0;
      if (v1 == v2) f = f | CMP_EQL;
      if (v1 < v2)  f = f | CMP_LST;
      if (v1 > v2)  f = f | CMP_GRT;
      if (v1 != v2) f = f | CMP_NEQ;
      if (v1 <= v2) f = f | CMP_LTE;
      if (v1 >= v2) f = f | CMP_GRE;
      if ((v1 != '0) && (v2 != '0)) f = f | CMP_AND;
      if ((v1 ^ v2) != '0) f = f | CMP_XOR;
      if ((v1 != '0) || (v2 != '0)) f = f | CMP_COR;
      return f;
   endfunction

   // encoded instruction length in bytes
   always_comb begin
      unique case (ins_ff.opcode) inside
         OPC_ADD, OPC_SUB, OPC_MUL, OPC_DIV: ins_len = 3'd4;
         OPC_IMM:  ins_len = 3'd3;
         OPC_MOV:  ins_len = 3'd5;
         OPC_SHOW: ins_len = 3'd1;
         OPC_JMP:  ins_len = ins_ff.target_is_reg ? 3'd4 : 3'd5;
         OPC_CMP:  ins_len = 3'd1 + (ins_ff.first_is_reg ? 3'd2 : 3'd3)
                                  + (ins_ff.second_is_reg ? 3'd2 : 3'd3);
         default:  ins_len = 3'd0;
      endcase
   end

   assign pc_adv = pc_ff + {13'd0, ins_len};

   // register file read port
   always_comb begin
      unique case (cmd.rf_sel)
         RSEL_A:  rf_ridx = ins_ff.src_reg_a;
         RSEL_B:  rf_ridx = ins_ff.src_reg_b;
         RSEL_D:  rf_ridx = ins_ff.dest_reg;
         default: rf_ridx = ins_ff.src_reg_a;
      endcase
   end

   // capture index is the one read in the previous cycle
   logic [2:0] cap_idx;
   always_comb begin
      if (cmd.cap_a) begin
         cap_idx = ins_ff.src_reg_a;
      end else if (cmd.cap_b) begin
         cap_idx = ins_ff.src_reg_b;
      end else begin
         cap_idx = ins_ff.dest_reg;
      end
      if (cap_idx == REG_PC) begin
         rf_raw = pc_ff;
      end else if (cap_idx == REG_FLAGS) begin
         rf_raw = flags_ff;
      end else begin
         rf_raw = rf_valid_ff[cap_idx] ? rf_rdata : 16'd0;
      end
      // the program counter reads as already advanced
      rf_eff = (cap_idx == REG_PC) ? pc_adv : rf_raw;
   end

   always_comb begin
      if (ins_ff.opcode > OPC_CMP) begin
         fault_now = FLT_OPCODE;
      end else if ((ins_ff.opcode == OPC_DIV) && bzero_ff) begin
         fault_now = FLT_DIVZERO;
      end else begin
         fault_now = FLT_NONE;
      end
   end

   assign mul_lo    = opa_ff * opb_ff;
   assign mov_val   = ins_ff.src_is_reg ? opa_ff : mv_ff;
   assign cmp_val   = cmp_flags(ins_ff.first_is_reg ? opa_ff : ins_ff.imm_first,
                                ins_ff.second_is_reg ? opb_ff : ins_ff.imm_second);
   assign jmp_taken = ((flags_ff & {8'd0, ins_ff.jump_mask}) != 16'd0);

   // register write at commit
   always_comb begin
      wr_en  = 1'b0;
      wr_idx = ins_ff.dest_reg;
      wr_val = opa_ff + opb_ff;
      unique case (ins_ff.opcode) inside
         OPC_ADD: begin
            wr_en = 1'b1;
         end
         OPC_SUB: begin
            wr_en  = 1'b1;
            wr_val = opa_ff - opb_ff;
         end
         OPC_MUL: begin
            wr_en  = 1'b1;
            wr_val = mul_lo;
         end
         OPC_DIV: begin
            wr_en  = 1'b1;
            wr_val = div_quo;
         end
         OPC_IMM: begin
            wr_en  = 1'b1;
            wr_idx = REG_IMM;
            wr_val = ins_ff.imm_first;
         end
         OPC_MOV: begin
            wr_en  = ins_ff.dest_is_reg;
            wr_val = mov_val;
         end
         OPC_JMP: begin
            wr_en  = jmp_taken;
            wr_idx = REG_PC;
            wr_val = ins_ff.target_is_reg ? opa_ff : ins_ff.imm_first;
         end
         OPC_CMP: begin
            wr_en  = 1'b1;
            wr_idx = REG_FLAGS;
            wr_val = cmp_val;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   assign rf_we = cmd.commit && (fault_now == FLT_NONE) && wr_en;

   // address reduction, two stages: reciprocal multiply, then multiply back and subtract
   assign mod_src  = (cmd.mod_sel == MSEL_D) ? opd_ff : opa_ff;
   assign mod_prod = {17'd0, mod_src} * {16'd0, ModRecip};
   assign mod_back = {17'd0, mod_q_ff} * {16'd0, ModWords};
   assign mod_rem  = mod_val_ff - mod_back[15:0];

   assign dm_we    = cmd.clr || cmd.mem_wr;
   assign dm_waddr = cmd.clr ? clr_ff[AddrW-1:0] : addr_ff;
   assign dm_wdata = cmd.clr ? 16'd0 : mov_val;

   always_comb begin
      ins_in       = cmd.cap_instr ? req_item_type'(req_tdata) : ins_ff;
      opa_in       = cmd.cap_a ? rf_eff : opa_ff;
      opb_in       = cmd.cap_b ? rf_eff : opb_ff;
      bzero_in     = cmd.cap_b ? (rf_raw == 16'd0) : bzero_ff;
      opd_in       = cmd.cap_d ? rf_eff : opd_ff;
      mv_in        = cmd.cap_v ? dm_rdata : mv_ff;
      mod_val_in   = mod_src;
      mod_q_in     = 16'(mod_prod >> ModShift);
      addr_in      = cmd.cap_addr ? mod_rem[AddrW-1:0] : addr_ff;
      clr_in       = cmd.clr ? (clr_ff + 1'b1) : clr_ff;
      pc_in        = pc_ff;
      flags_in     = flags_ff;
      rf_valid_in  = rf_valid_ff;
      fault_in     = cmd.commit ? fault_now : fault_ff;
      if (cmd.commit && (fault_now == FLT_NONE)) begin
         pc_in = (wr_en && (wr_idx == REG_PC)) ? wr_val : pc_adv;
         if (wr_en && (wr_idx == REG_FLAGS)) begin
            flags_in = wr_val;
         end
      end
      if (rf_we) begin
         rf_valid_in[wr_idx] = 1'b1;
      end
      rsp_in = rsp_ff;
      if (cmd.rsp_load) begin
         rsp_in.pad       = '0;
         rsp_in.flags_now = flags_ff;
         rsp_in.fault     = fault_ff;
         rsp_in.next_pc   = pc_ff;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= '0;
         flags_ff     <= '0;
         clr_ff       <= '0;
         rf_valid_ff  <= '0;
         fault_ff     <= FLT_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         flags_ff     <= flags_in;
         clr_ff       <= clr_in;
         rf_valid_ff  <= rf_valid_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ins_ff     <= ins_in;
      opa_ff     <= opa_in;
      opb_ff     <= opb_in;
      bzero_ff   <= bzero_in;
      opd_ff     <= opd_in;
      mv_ff      <= mv_in;
      mod_val_ff <= mod_val_in;
      mod_q_ff   <= mod_q_in;
      addr_ff    <= addr_in;
      rsp_ff     <= rsp_in;
   end

   tiex_ram #(
      .WIDTH (16),
      .DEPTH (8)
   ) u_regfile (
      .clock (clock),
      .we    (rf_we),
      .waddr (wr_idx),
      .wdata (wr_val),
      .raddr (rf_ridx),
      .rdata (rf_rdata)
   );

   tiex_ram #(
      .WIDTH (16),
      .DEPTH (MEM_WORDS)
   ) u_datamem (
      .clock (clock),
      .we    (dm_we),
      .waddr (dm_waddr),
      .wdata (dm_wdata),
      .raddr (addr_ff),
      .rdata (dm_rdata)
   );

   tiex_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (opa_ff),
      .divisor  (opb_ff),
      .quotient (div_quo),
      .done     (div_done)
   );

   assign status.opcode      = ins_ff.opcode;
   assign status.src_is_reg  = ins_ff.src_is_reg;
   assign status.dest_is_reg = ins_ff.dest_is_reg;
   assign status.fault_any   = (fault_now != FLT_NONE);
   assign status.div_done    = div_done;
   assign status.clr_done    = (clr_ff == ClrEnd);
   assign status.rsp_free    = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

endmodule

// ----- design/tiex_ctrl.sv -----
// ----------------------------------------------------------------------------
// tiex_ctrl
// Execute sequencer: operand reads, dispatch, divider and memory steps,
// commit and result hand-off.
// ----------------------------------------------------------------------------
module tiex_ctrl import tiex_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clr_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_RD_A;
         end
         ST_RD_A: state_in = ST_RD_B;
         ST_RD_B: state_in = ST_RD_D;
         ST_RD_D: state_in = ST_EXEC;
         ST_EXEC: begin
            if (status.fault_any) begin
               state_in = ST_DONE;
            end else if (status.opcode == OPC_DIV) begin
               state_in = ST_DIV_WAIT;
            end else if (status.opcode == OPC_MOV) begin
               if (!status.src_is_reg) begin
                  state_in = ST_MODA_WAIT;
               end else if (!status.dest_is_reg) begin
                  state_in = ST_MODD_START;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DIV_WAIT: begin
            if (status.div_done) state_in = ST_DONE;
         end
         ST_MODA_WAIT: state_in = ST_MEM_RD;
         ST_MEM_RD: state_in = ST_MEM_CAP;
         ST_MEM_CAP: begin
            state_in = status.dest_is_reg ? ST_MOV_WB : ST_MODD_START;
         end
         ST_MODD_START: state_in = ST_MODD_WAIT;
         ST_MODD_WAIT: state_in = ST_MEM_WR;
         ST_MEM_WR: state_in = ST_DONE;
         ST_MOV_WB: state_in = ST_DONE;
         ST_DONE: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd         = '0;
      cmd.rf_sel  = RSEL_A;
      cmd.mod_sel = MSEL_A;
      req_tready  = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr = !status.clr_done;
         end
         ST_IDLE: begin
            req_tready    = 1'b1;
            cmd.cap_instr = req_tvalid;
         end
         ST_RD_A: begin
            cmd.rf_sel = RSEL_A;
         end
         ST_RD_B: begin
            cmd.rf_sel = RSEL_B;
            cmd.cap_a  = 1'b1;
         end
         ST_RD_D: begin
            cmd.rf_sel = RSEL_D;
            cmd.cap_b  = 1'b1;
         end
         ST_EXEC: begin
            cmd.cap_d = 1'b1;
            if (status.fault_any) begin
               cmd.commit = 1'b1;
            end else if (status.opcode == OPC_DIV) begin
               cmd.div_start = 1'b1;
            end else if (status.opcode == OPC_MOV) begin
               if (!status.src_is_reg) begin
                  // source address enters the reduction stage
                  cmd.mod_sel = MSEL_A;
               end else if (status.dest_is_reg) begin
                  cmd.commit = 1'b1;
               end
            end else begin
               cmd.commit = 1'b1;
            end
         end
         ST_DIV_WAIT: begin
            cmd.commit = status.div_done;
         end
         ST_MODA_WAIT: begin
            cmd.cap_addr = 1'b1;
         end
         ST_MEM_RD: begin
            cmd.cap_v = 1'b0;
         end
         ST_MEM_CAP: begin
            cmd.cap_v = 1'b1;
         end
         ST_MODD_START: begin
            cmd.mod_sel = MSEL_D;
         end
         ST_MODD_WAIT: begin
            cmd.cap_addr = 1'b1;
         end
         ST_MEM_WR: begin
            cmd.mem_wr = 1'b1;
            cmd.commit = 1'b1;
         end
         ST_MOV_WB: begin
            cmd.commit = 1'b1;
         end
         ST_DONE: begin
            cmd.rsp_load = status.rsp_free;
         end
         default: begin
            cmd.clr = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- dv/toy_isa_execute_unit_tb.sv -----
// ----------------------------------------------------------------------------
// toy_isa_execute_unit_tb
// Self-checking bench for the execute unit: a directed table of instructions
// is followed by random instruction streams under several idle/stall mixes.
// Each result is compared with a typed-in expectation or with an in-bench model
// of the register file and the data memory.
// ----------------------------------------------------------------------------
module toy_isa_execute_unit_tb;
   import tiex_pkg::*;

   localparam int MEM_DEPTH      = 64;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 60;
   localparam int PHASE_ITEMS    = 375;
   localparam int MAX_REPORTS    = 10;

   typedef struct {
      req_item_type instr;
      bit           known;
      rsp_item_type result;
   } table_row_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   // opcode, dest_reg, src_reg_a, src_reg_b, dest_is_reg, src_is_reg, jump_mask,
   // target_is_reg, first_is_reg, second_is_reg, imm_first, imm_second, zero
   logic [63:0] req_tdata   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   // next_pc, fault, flags_now, zero
   logic [39:0] rsp_tdata;

   // architectural state mirrored by the bench
   logic [15:0] arch_regs [8];
   logic [15:0] data_mem  [MEM_DEPTH];

   rsp_item_type  expected_results [$];
   table_row_type directed_rows [$];
   int            sender_idle_pct    = 0;
   int            receiver_stall_pct = 0;
   int            fail_count         = 0;
   int            quiet_cycles       = 0;
   rsp_item_type  got_result;
   rsp_item_type  want_result;

   toy_isa_execute_unit #(
      .MEM_WORDS (MEM_DEPTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   // execute one instruction on the mirrored state, return what the unit reports
   function automatic rsp_item_type exec_instr(req_item_type r);
      logic [15:0]  len;
      logic [1:0]   flt;
      logic [15:0]  a;
      logic [15:0]  b;
      logic [15:0]  v;
      logic [15:0]  v1;
      logic [15:0]  v2;
      logic [15:0]  fl;
      rsp_item_type res;
      flt = FLT_NONE;
      len = '0;
      case (r.opcode)
         OPC_ADD, OPC_SUB, OPC_MUL, OPC_DIV: len = 16'd4;
         OPC_IMM:  len = 16'd3;
         OPC_MOV:  len = 16'd5;
         OPC_SHOW: len = 16'd1;
         OPC_JMP:  len = r.target_is_reg ? 16'd4 : 16'd5;
         OPC_CMP:  len = 16'd1 + (r.first_is_reg ? 16'd2 : 16'd3)
                               + (r.second_is_reg ? 16'd2 : 16'd3);
         default:  flt = FLT_OPCODE;
      endcase
      if (r.opcode == OPC_DIV && arch_regs[r.src_reg_b] == 16'd0) flt = FLT_DIVZERO;
      if (flt == FLT_NONE) begin
         // pc advances first, so reading register 0 gives the next address
         arch_regs[REG_PC] = arch_regs[REG_PC] + len;
         a = arch_regs[r.src_reg_a];
         b = arch_regs[r.src_reg_b];
         case (r.opcode)
            OPC_ADD: arch_regs[r.dest_reg] = a + b;
            OPC_SUB: arch_regs[r.dest_reg] = a - b;
            OPC_MUL: arch_regs[r.dest_reg] = a * b;
            OPC_DIV: arch_regs[r.dest_reg] = a / b;
            OPC_IMM: arch_regs[REG_IMM] = r.imm_first;
            OPC_MOV: begin
               v = r.src_is_reg ? a : data_mem[a % MEM_DEPTH];
               if (r.dest_is_reg) arch_regs[r.dest_reg] = v;
               else data_mem[arch_regs[r.dest_reg] % MEM_DEPTH] = v;
            end
            OPC_JMP: begin
               if ((arch_regs[REG_FLAGS] & {8'h00, r.jump_mask}) != 16'd0)
                  arch_regs[REG_PC] = r.target_is_reg ? a : r.imm_first;
            end
            OPC_CMP: begin
               v1 = r.first_is_reg ? a : r.imm_first;
               v2 = r.second_is_reg ? b : r.imm_second;
               fl = '0;
               if (v1 == v2) fl = fl | CMP_EQL;
               if (v1 < v2) fl = fl | CMP_LST;
               if (v1 > v2) fl = fl | CMP_GRT;
               if (v1 != v2) fl = fl | CMP_NEQ;
               if (v1 <= v2) fl = fl | CMP_LTE;
               if (v1 >= v2) fl = fl | CMP_GRE;
               if (v1 != 16'd0 && v2 != 16'd0) fl = fl | CMP_AND;
               if ((v1 ^ v2) != 16'd0) fl = fl | CMP_XOR;
               if (v1 != 16'd0 || v2 != 16'd0) fl = fl | CMP_COR;
               arch_regs[REG_FLAGS] = fl;
            end
            default: ;
         endcase
      end
      res = '0;
      res.next_pc   = arch_regs[REG_PC];
      res.fault     = flt;
      res.flags_now = arch_regs[REG_FLAGS];
      return res;
   endfunction

   function automatic req_item_type make_instr(
      logic [7:0] op, logic [2:0] rd, logic [2:0] ra, logic [2:0] rb,
      logic dreg, logic sreg, logic [7:0] mask, logic treg, logic freg,
      logic sreg2, logic [15:0] imm1, logic [15:0] imm2);
      req_item_type r;
      r = '0;
      r.opcode        = op;
      r.dest_reg      = rd;
      r.src_reg_a     = ra;
      r.src_reg_b     = rb;
      r.dest_is_reg   = dreg;
      r.src_is_reg    = sreg;
      r.jump_mask     = mask;
      r.target_is_reg = treg;
      r.first_is_reg  = freg;
      r.second_is_reg = sreg2;
      r.imm_first     = imm1;
      r.imm_second    = imm2;
      return r;
   endfunction

   function automatic logic [15:0] rand_word();
      // small values now and then so that compares hit equality
      if ($urandom_range(3) == 0) return 16'($urandom_range(0, 3));
      return 16'($urandom);
   endfunction

   function automatic req_item_type rand_instr();
      req_item_type r;
      r = '0;
      // mostly legal opcodes, a few unknown ones across the whole byte
      if ($urandom_range(99) < 88) r.opcode = 8'($urandom_range(0, 8));
      else r.opcode = 8'($urandom_range(0, 255));
      r.dest_reg      = 3'($urandom);
      r.src_reg_a     = 3'($urandom);
      r.src_reg_b     = 3'($urandom);
      r.dest_is_reg   = 1'($urandom);
      r.src_is_reg    = 1'($urandom);
      r.jump_mask     = 8'($urandom);
      r.target_is_reg = 1'($urandom);
      r.first_is_reg  = 1'($urandom);
      r.second_is_reg = 1'($urandom);
      r.imm_first     = rand_word();
      r.imm_second    = rand_word();
      return r;
   endfunction

   task automatic add_row(req_item_type instr, bit known, logic [15:0] pc,
                          logic [1:0] flt, logic [15:0] flags);
      table_row_type row;
      row.instr  = instr;
      row.known  = known;
      row.result = '0;
      row.result.next_pc   = pc;
      row.result.fault     = flt;
      row.result.flags_now = flags;
      directed_rows.push_back(row);
   endtask

   // record the expectation and present the instruction until it is taken
   task automatic issue_instr(req_item_type r, bit known, rsp_item_type typed);
      rsp_item_type predicted;
      predicted = exec_instr(r);
      expected_results.push_back(known ? typed : predicted);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= r;
      do @(posedge clock); while (!req_tready);
   endtask

   // hold off the sender until every outstanding result has come back
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
   endtask

   task automatic run_phase(int idle_pct, int stall_pct, int count);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      repeat (count) issue_instr(rand_instr(), 1'b0, '0);
      drain_results();
   endtask

   // receiver back-pressure, redrawn every cycle
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // result checker and idle watchdog counter
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (rsp_tvalid && rsp_tready) begin
            got_result = rsp_tdata;
            if (expected_results.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("unexpected result transfer: pc=%h fault=%0d flags=%h",
                           got_result.next_pc, got_result.fault, got_result.flags_now);
            end else begin
               want_result = expected_results.pop_front();
               if (got_result.next_pc !== want_result.next_pc ||
                   got_result.fault !== want_result.fault ||
                   got_result.flags_now !== want_result.flags_now) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS)
                     $display("result mismatch: expected pc=%h fault=%0d flags=%h, got pc=%h fault=%0d flags=%h",
                              want_result.next_pc, want_result.fault, want_result.flags_now,
                              got_result.next_pc, got_result.fault, got_result.flags_now);
               end
            end
         end
      end
   end

   // no transfer in either direction for too long means the unit is hung
   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      foreach (arch_regs[i]) arch_regs[i] = '0;
      foreach (data_mem[i]) data_mem[i] = '0;

      // directed table: expected results typed in where they are obvious
      // show right after reset, then every field at its top value with an unknown opcode
      add_row(make_instr(OPC_SHOW, 0, 0, 0, 0, 0, 8'h00, 0, 0, 0, 16'h0000, 16'h0000),
              1, 16'd1, FLT_NONE, 16'h0000);
      add_row(make_instr(8'hFF, 7, 7, 7, 1, 1, 8'hFF, 1, 1, 1, 16'hFFFF, 16'hFFFF),
              1, 16'd1, FLT_OPCODE, 16'h0000);
      // divide by zero leaves the pc on the faulting instruction
      add_row(make_instr(OPC_DIV, 3, 4, 5, 0, 0, 8'h00, 0, 0, 0, 16'h0000, 16'h0000),
              1, 16'd1, FLT_DIVZERO, 16'h0000);
      add_row(make_instr(OPC_IMM, 0, 0, 0, 0, 0, 8'h00, 0, 0, 0, 16'hFFFF, 16'h0000),
              1, 16'd4, FLT_NONE, 16'h0000);
      add_row(make_instr(OPC_CMP, 0, 0, 0, 0, 0, 8'h00, 0, 0, 0, 16'h0000, 16'h0000),
              1, 16'd11, FLT_NONE, CMP_EQL | CMP_LTE | CMP_GRE);
      add_row(make_instr(OPC_CMP, 0, 1, 0, 0, 0, 8'h00, 0, 1, 0, 16'h0000, 16'h0000),
              1, 16'd17, FLT_NONE,
              CMP_GRT | CMP_NEQ | CMP_GRE | CMP_XOR | CMP_COR);
      add_row(make_instr(OPC_JMP, 0, 0, 0, 0, 0, 8'hFF, 0, 0, 0, 16'h1234, 16'h0000),
              1, 16'h1234, FLT_NONE,
              CMP_GRT | CMP_NEQ | CMP_GRE | CMP_XOR | CMP_COR);
      // register moves and arithmetic with wrap-around
      add_row(make_instr(OPC_MOV, 4, 1, 0, 1, 1, 8'h00, 0, 0, 0, 16'h0000, 16'h0000), 0, 0, 0, 0);
      add_row(make_instr(OPC_ADD, 5, 4, 1, 0, 0, 8'h00, 0, 0, 0, 16'h0000, 16'h0000), 0, 0, 0, 0);
      add_row(make_instr(OPC_MUL, 6, 4, 4, 0, 0, 8'h00, 0, 0, 0, 16'h0000, 16'h0000), 0, 0, 0, 0);
      add_row(make_instr(OPC_SUB, 7, 6, 4, 0, 0, 8'h00, 0, 0, 0, 16'h0000, 16'h0000), 0, 0, 0, 0);
      add_row(make_instr(OPC_DIV, 3, 4, 7, 0, 0, 8'h00, 0, 0, 0, 16'h0000, 16'h0000), 0, 0, 0, 0);
      // memory moves with addresses that wrap to the memory size
      add_row(make_instr(OPC_MOV, 5, 4, 0, 0, 1, 8'h00, 0, 0, 0, 16'h0000, 16'h0000), 0, 0, 0, 0);
      add_row(make_instr(OPC_MOV, 6, 5, 0, 1, 0, 8'h00, 0, 0, 0, 16'h0000, 16'h0000), 0, 0, 0, 0);
      add_row(make_instr(OPC_MOV, 1, 5, 0, 0, 0, 8'h00, 0, 0, 0, 16'h0000, 16'h0000), 0, 0, 0, 0);
      // pc read as an operand, pc and flags as destinations
      add_row(make_instr(OPC_ADD, 4, 0, 0, 0, 0, 8'h00, 0, 0, 0, 16'h0000, 16'h0000), 0, 0, 0, 0);
      add_row(make_instr(OPC_MOV, 0, 7, 0, 1, 1, 8'h00, 0, 0, 0, 16'h0000, 16'h0000), 0, 0, 0, 0);
      add_row(make_instr(OPC_ADD, 2, 1, 6, 0, 0, 8'h00, 0, 0, 0, 16'h0000, 16'h0000), 0, 0, 0, 0);
      // jumps with an empty and a full mask, register target
      add_row(make_instr(OPC_JMP, 0, 3, 0, 0, 0, 8'h00, 1, 0, 0, 16'h0000, 16'h0000), 0, 0, 0, 0);
      add_row(make_instr(OPC_JMP, 0, 3, 0, 0, 0, 8'hFF, 1, 0, 0, 16'h0000, 16'h0000), 0, 0, 0, 0);
      add_row(make_instr(OPC_CMP, 0, 0, 0, 0, 0, 8'h00, 0, 1, 1, 16'h0000, 16'h0000), 0, 0, 0, 0);
      add_row(make_instr(OPC_CMP, 0, 0, 3, 0, 0, 8'h00, 0, 0, 1, 16'h0000, 16'h0000), 0, 0, 0, 0);
      add_row(make_instr(8'd9, 0, 0, 0, 0, 0, 8'h00, 0, 0, 0, 16'h0000, 16'h0000), 0, 0, 0, 0);
      add_row(make_instr(OPC_IMM, 0, 0, 0, 0, 0, 8'h00, 0, 0, 0, 16'h0000, 16'h0000), 0, 0, 0, 0);
      add_row(make_instr(OPC_CMP, 0, 0, 0, 0, 0, 8'h00, 0, 0, 0, 16'hFFFF, 16'hFFFF), 0, 0, 0, 0);

      repeat (6) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         issue_instr(directed_rows[i].instr, directed_rows[i].known, directed_rows[i].result);
      drain_results();

      // random streams: back to back, sender idle, receiver stalling, both
      run_phase(0, 0, PHASE_ITEMS);
      run_phase(71, 0, PHASE_ITEMS);
      run_phase(0, 71, PHASE_ITEMS);
      run_phase(25, 25, PHASE_ITEMS);

      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
design/tiex_pkg.sv
design/tiex_ram.sv
design/tiex_div.sv
design/tiex_dpath.sv
design/tiex_ctrl.sv
design/toy_isa_execute_unit.sv
dv/toy_isa_execute_unit_tb.sv
